[rtl/triple_key_lookup_or_insert_table_top_defines.svh]
// assertion macros for the lookup-or-insert table
`ifndef TRIPLE_KEY_LOOKUP_OR_INSERT_TABLE_TOP_DEFINES_SVH
`define TRIPLE_KEY_LOOKUP_OR_INSERT_TABLE_TOP_DEFINES_SVH

`ifndef SYNTH
// checked only outside reset
`define TKLT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tklt assertion failed");
// checked at every edge, reset included
`define TKLT_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("tklt assertion failed");
`else
`define TKLT_ASSERT(name, clk, rst, prop)
`define TKLT_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

[rtl/tklt_pkg.sv]
package tklt_pkg;

   // table geometry
   localparam int TABLE_DEPTH    = 1024;
   localparam int DOMAIN_ID_BITS = 16;
   localparam int CLIENT_ID_BITS = 16;

   // fixed field widths of the channels
   localparam int DOMAIN_W   = 16;
   localparam int CLIENT_W   = 16;
   localparam int QTYPE_W    = 5;
   localparam int IDX_OUT_W  = 10;
   localparam int USED_OUT_W = 11;
   localparam int OUTCOME_W  = 2;

   localparam int KEY_W = DOMAIN_ID_BITS + CLIENT_ID_BITS + QTYPE_W;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef logic [KEY_W-1:0]     key_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [OUTCOME_W-1:0] outcome_type;

   localparam outcome_type OUT_FOUND     = 2'd0;
   localparam outcome_type OUT_CREATED   = 2'd1;
   localparam outcome_type OUT_NOT_FOUND = 2'd2;
   localparam outcome_type OUT_FULL      = 2'd3;

endpackage

[rtl/tklt_if.sv]
interface tklt_req_if import tklt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DOMAIN_W-1:0] domain_id;
   logic [CLIENT_W-1:0] client_id;
   logic [QTYPE_W-1:0]  rec_type;
   logic                alloc_en;

   modport source (output valid, domain_id, client_id, rec_type, alloc_en,
                   input ready);
   modport sink (input valid, domain_id, client_id, rec_type, alloc_en,
                 output ready);
endinterface

interface tklt_rsp_if import tklt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [IDX_OUT_W-1:0]  entry_index;
   logic [OUTCOME_W-1:0]  outcome;
   logic [USED_OUT_W-1:0] entries_used;

   modport source (output valid, entry_index, outcome, entries_used, input ready);
   modport sink (input valid, entry_index, outcome, entries_used, output ready);
endinterface

[rtl/tklt_ram.sv]
module tklt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/triple_key_lookup_or_insert_table_top.sv]
// one request at a time: stored keys are compared in order from index 0, one per
//   cycle from the single read port of the key memory, the first match winning;
//   a miss or an empty table goes through the miss state, which appends the key
//   when alloc_en is set and the table is not full; the result is registered
// reset clears the entry count and control; key memory needs no clearing pass
`include "triple_key_lookup_or_insert_table_top_defines.svh"

module triple_key_lookup_or_insert_table_top import tklt_pkg::*; (
   input logic       clock,
   input logic       reset,
   tklt_req_if.sink  req_port,
   tklt_rsp_if.source rsp_port
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_MISS = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   cnt_type     count_ff, count_in;
   idx_type     scan_idx_ff, scan_idx_in;
   key_type     key_ff, key_in;
   logic        create_ff, create_in;
   idx_type     res_idx_ff, res_idx_in;
   outcome_type res_outcome_ff, res_outcome_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_OUT_W-1:0]  rsp_index_ff, rsp_index_in;
   outcome_type           rsp_outcome_ff, rsp_outcome_in;
   logic [USED_OUT_W-1:0] rsp_used_ff, rsp_used_in;

   logic    rd_en, wr_en;
   idx_type rd_addr;
   key_type rd_data;
   logic    req_accept, hit, last, full, load_out;

   assign req_accept = req_port.valid & req_port.ready;
   assign hit  = (rd_data == key_ff);
   assign last = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == count_ff);
   assign full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign load_out = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_port.ready);

   assign req_port.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      scan_idx_in    = scan_idx_ff;
      key_in         = key_ff;
      create_in      = create_ff;
      res_idx_in     = res_idx_ff;
      res_outcome_in = res_outcome_ff;
      rd_en          = 1'b0;
      rd_addr        = scan_idx_ff + idx_type'(1);
      wr_en          = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (req_accept) begin
               key_in = {DOMAIN_ID_BITS'(req_port.domain_id),
                         CLIENT_ID_BITS'(req_port.client_id),
                         req_port.rec_type};
               create_in   = req_port.alloc_en;
               scan_idx_in = '0;
               if (count_ff == '0) begin
                  state_in = S_MISS;
               end else begin
                  rd_en    = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // rd_data holds the entry at scan_idx_ff
            if (hit) begin
               res_idx_in     = scan_idx_ff;
               res_outcome_in = OUT_FOUND;
               state_in       = S_OUT;
            end else if (last) begin
               state_in = S_MISS;
            end else begin
               rd_en       = 1'b1;
               scan_idx_in = scan_idx_ff + idx_type'(1);
            end
         end
         S_MISS: begin
            res_idx_in = '0;
            state_in   = S_OUT;
            if (!create_ff) begin
               res_outcome_in = OUT_NOT_FOUND;
            end else if (full) begin
               res_outcome_in = OUT_FULL;
            end else begin
               wr_en          = 1'b1;
               res_idx_in     = count_ff[IDX_W-1:0];
               res_outcome_in = OUT_CREATED;
               count_in       = count_ff + CNT_W'(1);
            end
         end
         S_OUT: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register holds the finished transaction while the sink stalls
   always_comb begin
      rsp_valid_in   = rsp_valid_ff & ~rsp_port.ready;
      rsp_index_in   = rsp_index_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_used_in    = rsp_used_ff;
      if (load_out) begin
         rsp_valid_in   = 1'b1;
         rsp_index_in   = IDX_OUT_W'(res_idx_ff);
         rsp_outcome_in = res_outcome_ff;
         rsp_used_in    = USED_OUT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_idx_ff    <= scan_idx_in;
      key_ff         <= key_in;
      create_ff      <= create_in;
      res_idx_ff     <= res_idx_in;
      res_outcome_ff <= res_outcome_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_used_ff    <= rsp_used_in;
   end

   tklt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.entry_index  = rsp_index_ff;
   assign rsp_port.outcome      = rsp_outcome_ff;
   assign rsp_port.entries_used = rsp_used_ff;

   `TKLT_ASSERT(a_count_bounded, clock, reset, count_ff <= CNT_W'(TABLE_DEPTH))
   `TKLT_ASSERT(a_write_bumps_count, clock, reset,
      wr_en |=> count_ff == $past(count_ff) + CNT_W'(1))
   `TKLT_ASSERT(a_accept_leaves_idle, clock, reset,
      (req_port.valid && req_port.ready) |=> state_ff != S_IDLE)
   `TKLT_ASSERT(a_created_counts, clock, reset,
      (rsp_port.valid && rsp_port.outcome == OUT_CREATED) |-> rsp_port.entries_used != '0)
   `TKLT_ASSERT_ALWAYS(a_reset_clears, clock,
      reset |=> (count_ff == '0 && !rsp_valid_ff && state_ff == S_IDLE))

endmodule

[tb/sv/triple_key_lookup_or_insert_table_top_tb.sv]
module triple_key_lookup_or_insert_table_top_tb import tklt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 580;
   localparam int IDLE_PERCENT   = 25;
   localparam int CALM_FIRST     = 300;
   localparam int CALM_LAST      = 420;
   localparam int PRINT_LIMIT    = 40;
   localparam int WATCHDOG_LIMIT = 4 * (TABLE_DEPTH + 3) + 400;

   typedef struct packed {
      logic [DOMAIN_W-1:0] domain_id;
      logic [CLIENT_W-1:0] client_id;
      logic [QTYPE_W-1:0]  rec_type;
      logic                alloc_en;
   } lookup_req_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0]  entry_index;
      outcome_type           outcome;
      logic [USED_OUT_W-1:0] entries_used;
   } lookup_rsp_type;

   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   lookup_req_type req_item  = '0;
   logic           rsp_ready = 1'b0;

   tklt_req_if req_bus ();
   tklt_rsp_if rsp_bus ();

   assign req_bus.valid     = req_valid;
   assign req_bus.domain_id = req_item.domain_id;
   assign req_bus.client_id = req_item.client_id;
   assign req_bus.rec_type  = req_item.rec_type;
   assign req_bus.alloc_en  = req_item.alloc_en;
   assign rsp_bus.ready     = rsp_ready;

   triple_key_lookup_or_insert_table_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   lookup_req_type pending_requests[$];
   lookup_rsp_type expected_replies[$];
   lookup_req_type created_keys[$];

   // shadow copy of the key table
   key_type        shadow_keys[TABLE_DEPTH];
   int unsigned    shadow_count   = 0;
   int unsigned    accepted_count = 0;
   int             error_count    = 0;
   int             quiet_cycles   = 0;
   lookup_rsp_type oldest_reply;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic key_type table_key(lookup_req_type r);
      return {r.domain_id[DOMAIN_ID_BITS-1:0], r.client_id[CLIENT_ID_BITS-1:0],
              r.rec_type};
   endfunction

   task automatic lookup_or_insert(input lookup_req_type r);
      key_type        k;
      lookup_rsp_type res;
      bit             hit;
      k               = table_key(r);
      res.entry_index = '0;
      res.outcome     = OUT_NOT_FOUND;
      hit             = 1'b0;
      for (int i = 0; i < shadow_count; i++) begin
         if (!hit && shadow_keys[i] == k) begin
            hit             = 1'b1;
            res.entry_index = IDX_OUT_W'(i);
            res.outcome     = OUT_FOUND;
         end
      end
      if (!hit && r.alloc_en) begin
         if (shadow_count >= TABLE_DEPTH) begin
            res.outcome = OUT_FULL;
         end else begin
            res.entry_index           = IDX_OUT_W'(shadow_count);
            shadow_keys[shadow_count] = k;
            shadow_count++;
            res.outcome               = OUT_CREATED;
         end
      end
      res.entries_used = USED_OUT_W'(shadow_count);
      expected_replies.push_back(res);
   endtask

   task automatic report_mismatch(input string msg);
      error_count++;
      // keep the log short when everything goes wrong at once
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at %0t: %s", $time, msg);
   endtask

   function automatic bit take_break();
      if (accepted_count >= CALM_FIRST && accepted_count < CALM_LAST)
         return 1'b0;
      return $urandom_range(99) < IDLE_PERCENT;
   endfunction

   function automatic lookup_req_type random_key();
      lookup_req_type r;
      r.domain_id = DOMAIN_W'($urandom);
      r.client_id = CLIENT_W'($urandom);
      r.rec_type  = QTYPE_W'($urandom);
      r.alloc_en  = 1'($urandom_range(1));
      return r;
   endfunction

   task automatic add_request(input logic [DOMAIN_W-1:0] dom,
                              input logic [CLIENT_W-1:0] cli,
                              input logic [QTYPE_W-1:0]  qt,
                              input logic                cr);
      lookup_req_type r;
      r.domain_id = dom;
      r.client_id = cli;
      r.rec_type  = qt;
      r.alloc_en  = cr;
      if (cr)
         created_keys.push_back(r);
      pending_requests.push_back(r);
   endtask

   task automatic add_random_request();
      lookup_req_type r;
      int             pick;
      pick = $urandom_range(99);
      r    = random_key();
      if (pick < 70 && created_keys.size() != 0) begin
         r = created_keys[$urandom_range(created_keys.size() - 1)];
         // near miss: one bit off in one part of the key
         if (pick >= 55) begin
            case ($urandom_range(2))
               0: r.domain_id[$urandom_range(DOMAIN_W - 1)] ^= 1'b1;
               1: r.client_id[$urandom_range(CLIENT_W - 1)] ^= 1'b1;
               default: r.rec_type[$urandom_range(QTYPE_W - 1)] ^= 1'b1;
            endcase
         end
         r.alloc_en = 1'($urandom_range(1));
      end
      add_request(r.domain_id, r.client_id, r.rec_type, r.alloc_en);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_replies.size() != 0)
         @(posedge clock);
   endtask

   // request driver, prediction at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_bus.ready) begin
            lookup_or_insert(req_item);
            accepted_count++;
         end
         if (!req_valid || req_bus.ready) begin
            if (pending_requests.size() != 0 && !take_break()) begin
               req_item  <= pending_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("result with no request outstanding, index %0d",
                                         rsp_bus.entry_index));
            end else begin
               oldest_reply = expected_replies.pop_front();
               if (rsp_bus.entry_index !== oldest_reply.entry_index)
                  report_mismatch($sformatf("entry_index %0d, expected %0d",
                                            rsp_bus.entry_index, oldest_reply.entry_index));
               if (rsp_bus.outcome !== oldest_reply.outcome)
                  report_mismatch($sformatf("outcome %0d, expected %0d",
                                            rsp_bus.outcome, oldest_reply.outcome));
               if (rsp_bus.entries_used !== oldest_reply.entries_used)
                  report_mismatch($sformatf("entries_used %0d, expected %0d",
                                            rsp_bus.entries_used, oldest_reply.entries_used));
            end
         end
         rsp_ready <= !take_break();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_bus.ready) || (rsp_bus.valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      lookup_req_type r;
      lookup_req_type last_fill;
      int             n;
      last_fill = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty table, then keys that differ in one part only
      add_request(16'h0000, 16'h0000, 5'd0, 1'b0);
      add_request(16'h0000, 16'h0000, 5'd0, 1'b1);
      add_request(16'h0000, 16'h0000, 5'd0, 1'b0);
      add_request(16'h0000, 16'h0000, 5'd0, 1'b1);
      add_request(16'hFFFF, 16'hFFFF, 5'd31, 1'b1);
      add_request(16'hFFFF, 16'hFFFF, 5'd30, 1'b1);
      add_request(16'hFFFF, 16'hFFFE, 5'd31, 1'b1);
      add_request(16'h7FFF, 16'hFFFF, 5'd31, 1'b1);
      add_request(16'hFFFF, 16'hFFFF, 5'd31, 1'b0);
      add_request(16'h1234, 16'hABCD, 5'd16, 1'b1);
      add_request(16'h1234, 16'hABCD, 5'd17, 1'b1);
      add_request(16'h1234, 16'hABCD, 5'd17, 1'b0);
      add_request(16'h1234, 16'hABCD, 5'd0, 1'b0);
      add_request(16'h0000, 16'h0000, 5'd16, 1'b1);
      add_request(16'h8000, 16'h0001, 5'd1, 1'b1);
      add_request(16'h8000, 16'h0001, 5'd1, 1'b1);
      add_request(16'h0000, 16'h0000, 5'd0, 1'b0);
      add_request(16'h7FFF, 16'hFFFF, 5'd31, 1'b0);
      wait_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++)
         add_random_request();
      wait_drained();

      // fill the table to the last entry
      while (shadow_count < TABLE_DEPTH) begin
         n = int'(TABLE_DEPTH - shadow_count);
         repeat (n) begin
            r         = random_key();
            last_fill = r;
            add_request(r.domain_id, r.client_id, r.rec_type, 1'b1);
         end
         wait_drained();
      end

      // full table: misses with and without create, hits at both ends
      r = random_key();
      add_request(r.domain_id, r.client_id, r.rec_type, 1'b1);
      add_request(r.domain_id, r.client_id, r.rec_type, 1'b0);
      add_request(last_fill.domain_id, last_fill.client_id, last_fill.rec_type, 1'b1);
      add_request(last_fill.domain_id, last_fill.client_id, last_fill.rec_type, 1'b0);
      add_request(16'h0000, 16'h0000, 5'd0, 1'b1);
      add_request(16'hFFFF, 16'hFFFF, 5'd29, 1'b1);
      add_random_request();
      wait_drained();

      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (error_count == 0 && expected_replies.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/tklt_pkg.sv
rtl/tklt_if.sv
rtl/tklt_ram.sv
rtl/triple_key_lookup_or_insert_table_top.sv
tb/sv/triple_key_lookup_or_insert_table_top_tb.sv
